[rtl/core/btc_pkg.sv]
// Package for the bipartite two-coloring core.
// Holds field widths and fixed sizes shared by the core, its checker and its bench.
package btc_pkg;

    localparam int NODE_W    = 11;
    localparam int WIDX_W    = 4;
    localparam int WORD_BITS = 64;
    localparam int POS_W     = 6;
    localparam int NODE_CAP  = 1024;

    typedef logic [NODE_W-1:0]    t_node;
    typedef logic [WIDX_W-1:0]    t_widx;
    typedef logic [WORD_BITS-1:0] t_word;

endpackage

[rtl/core/bipartite_two_coloring_core.sv]
// Top level of the bipartite two-coloring core: edge intake, root walks and coloring pass.
// Depends on btc_pkg and btc_ram.
//
// An edge beat walks the stored links of both endpoints to their roots, one RAM read per
// step; an item without a usable edge and without last_item does not leave idle. The last
// item adds a decision state, then the coloring pass up to the node count (skipped when the
// graph is impossible), in which every node is read and checked and each non-root node also
// writes its color, and then a clearing pass over min(MAX_NODES,1024) entries that also runs
// once after reset. Busy stays high until the clearing pass is done.
// Results come out one per strobe cycle and the receiver cannot stall them.
module bipartite_two_coloring_core #(
    parameter int MAX_NODES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [btc_pkg::NODE_W-1:0]   i_node_a,
    input  logic [btc_pkg::NODE_W-1:0]   i_node_b,
    input  logic                         i_has_edge,
    input  logic                         i_last_item,
    input  logic                         i_cfg_we,
    input  logic [btc_pkg::NODE_W-1:0]   i_cfg_data,
    output logic                         o_valid,
    output logic                         o_possible,
    output logic [btc_pkg::WIDX_W-1:0]   o_word_index,
    output logic [btc_pkg::WORD_BITS-1:0] o_team_bits,
    output logic                         o_last_result
);

    localparam int NL = (MAX_NODES < btc_pkg::NODE_CAP) ? MAX_NODES : btc_pkg::NODE_CAP;
    localparam int IW = $clog2(NL);
    localparam int CW = $clog2(NL + 1);
    localparam int EW = IW + 1;

    localparam logic [btc_pkg::NODE_W-1:0] NL_CNT = btc_pkg::NODE_W'(NL);
    localparam logic [IW-1:0]              LAST_ADDR = IW'(NL - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FA_RD  = 4'd1;
    localparam logic [3:0] S_FA_CHK = 4'd2;
    localparam logic [3:0] S_FB_RD  = 4'd3;
    localparam logic [3:0] S_FB_CHK = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_C_RD   = 4'd6;
    localparam logic [3:0] S_C_CHK  = 4'd7;
    localparam logic [3:0] S_C_J    = 4'd8;
    localparam logic [3:0] S_CLR    = 4'd9;

    logic [3:0]                    r_state, n_state;
    logic [btc_pkg::NODE_W-1:0]    r_cfg_count;
    logic [CW-1:0]                 r_n, n_n;
    logic [IW-1:0]                 r_x, n_x;
    logic [IW-1:0]                 r_b, n_b;
    logic                          r_p, n_p;
    logic [IW-1:0]                 r_ra, n_ra;
    logic                          r_pa, n_pa;
    logic                          r_last, n_last;
    logic                          r_conf, n_conf;
    logic [CW-1:0]                 r_i, n_i;
    logic                          r_pi, n_pi;
    btc_pkg::t_word                r_word, n_word;
    logic [IW-1:0]                 r_clr, n_clr;
    logic                          r_valid, n_valid;
    logic                          r_possible, n_possible;
    btc_pkg::t_widx                r_widx, n_widx;
    btc_pkg::t_word                r_bits, n_bits;
    logic                          r_olast, n_olast;

    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic [EW-1:0]                 ram_wdata;
    logic [IW-1:0]                 ram_raddr;
    logic [EW-1:0]                 ram_rdata;
    logic [IW-1:0]                 rd_link;
    logic                          rd_par;

    logic [btc_pkg::NODE_W-1:0]    eff_count;
    logic                          edge_ok;
    logic [IW-1:0]                 ci;
    logic [CW-1:0]                 i_nxt;
    logic [btc_pkg::POS_W-1:0]     pos;
    logic                          color;
    btc_pkg::t_word                word_next;
    logic                          node_done;
    logic                          at_end;

    btc_ram #(
        .WIDTH (EW),
        .DEPTH (NL)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_link = ram_rdata[IW-1:0];
    assign rd_par  = ram_rdata[IW];

    always_comb begin
        if (r_cfg_count == '0) begin
            eff_count = btc_pkg::NODE_W'(1);
        end else if (r_cfg_count > NL_CNT) begin
            eff_count = NL_CNT;
        end else begin
            eff_count = r_cfg_count;
        end
    end

    assign edge_ok = i_has_edge && (i_node_a != '0) && (i_node_b != '0)
                     && (i_node_a <= eff_count) && (i_node_b <= eff_count);

    assign ci        = r_i[IW-1:0];
    assign i_nxt     = r_i + CW'(1);
    assign pos       = btc_pkg::POS_W'(r_i);
    assign at_end    = (i_nxt == r_n);
    assign color     = (r_state == S_C_J) ? (r_pi ^ rd_par) : 1'b0;
    assign word_next = r_word | (btc_pkg::WORD_BITS'(color) << pos);

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_x        = r_x;
        n_b        = r_b;
        n_p        = r_p;
        n_ra       = r_ra;
        n_pa       = r_pa;
        n_last     = r_last;
        n_conf     = r_conf;
        n_i        = r_i;
        n_pi       = r_pi;
        n_word     = r_word;
        n_clr      = r_clr;
        n_valid    = 1'b0;
        n_possible = r_possible;
        n_widx     = r_widx;
        n_bits     = r_bits;
        n_olast    = r_olast;
        ram_we     = 1'b0;
        ram_waddr  = r_x;
        ram_wdata  = '0;
        ram_raddr  = r_x;
        node_done  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_last = i_last_item;
                    n_n    = CW'(eff_count);
                    if (edge_ok) begin
                        n_x     = IW'(i_node_a - btc_pkg::NODE_W'(1));
                        n_b     = IW'(i_node_b - btc_pkg::NODE_W'(1));
                        n_p     = 1'b0;
                        n_state = S_FA_RD;
                    end else if (i_last_item) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_FA_RD: begin
                n_state = S_FA_CHK;
            end
            S_FA_CHK: begin
                ram_raddr = rd_link;
                if (rd_link == r_x) begin
                    n_ra    = r_x;
                    n_pa    = r_p;
                    n_x     = r_b;
                    n_p     = 1'b0;
                    n_state = S_FB_RD;
                end else begin
                    n_p = r_p ^ rd_par;
                    n_x = rd_link;
                end
            end
            S_FB_RD: begin
                n_state = S_FB_CHK;
            end
            S_FB_CHK: begin
                ram_raddr = rd_link;
                if (rd_link == r_x) begin
                    if (r_x == r_ra) begin
                        if (r_p == r_pa) begin
                            n_conf = 1'b1;
                        end
                    end else begin
                        ram_we = 1'b1;
                        if (r_x > r_ra) begin
                            ram_waddr = r_x;
                            ram_wdata = {r_p ^ r_pa ^ 1'b1, r_ra};
                        end else begin
                            ram_waddr = r_ra;
                            ram_wdata = {r_p ^ r_pa ^ 1'b1, r_x};
                        end
                    end
                    n_state = r_last ? S_DECIDE : S_IDLE;
                end else begin
                    n_p = r_p ^ rd_par;
                    n_x = rd_link;
                end
            end
            S_DECIDE: begin
                if (r_conf) begin
                    n_valid    = 1'b1;
                    n_possible = 1'b0;
                    n_widx     = '0;
                    n_bits     = '0;
                    n_olast    = 1'b1;
                    n_clr      = '0;
                    n_state    = S_CLR;
                end else begin
                    n_i     = '0;
                    n_word  = '0;
                    n_state = S_C_RD;
                end
            end
            S_C_RD: begin
                ram_raddr = ci;
                n_state   = S_C_CHK;
            end
            S_C_CHK: begin
                ram_raddr = rd_link;
                if (rd_link == ci) begin
                    node_done = 1'b1;
                end else begin
                    n_pi    = rd_par;
                    n_state = S_C_J;
                end
            end
            S_C_J: begin
                ram_we    = 1'b1;
                ram_waddr = ci;
                ram_wdata = {color, ci};
                node_done = 1'b1;
            end
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = {1'b0, r_clr};
                n_clr     = r_clr + IW'(1);
                n_conf    = 1'b0;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (node_done) begin
            n_i = i_nxt;
            if ((pos == '1) || at_end) begin
                n_valid    = 1'b1;
                n_possible = 1'b1;
                n_widx     = btc_pkg::WIDX_W'(r_i >> btc_pkg::POS_W);
                n_bits     = word_next;
                n_olast    = at_end;
                n_word     = '0;
            end else begin
                n_word = word_next;
            end
            if (at_end) begin
                n_clr   = '0;
                n_state = S_CLR;
            end else begin
                n_state = S_C_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_conf      <= 1'b0;
            r_valid     <= 1'b0;
            r_cfg_count <= btc_pkg::NODE_W'(1);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_conf  <= n_conf;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_cfg_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_x        <= n_x;
        r_b        <= n_b;
        r_p        <= n_p;
        r_ra       <= n_ra;
        r_pa       <= n_pa;
        r_last     <= n_last;
        r_i        <= n_i;
        r_pi       <= n_pi;
        r_word     <= n_word;
        r_possible <= n_possible;
        r_widx     <= n_widx;
        r_bits     <= n_bits;
        r_olast    <= n_olast;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_possible    = r_possible;
    assign o_word_index  = r_widx;
    assign o_team_bits   = r_bits;
    assign o_last_result = r_olast;

endmodule

[rtl/core/btc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the link and parity store of the core.
module btc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/btc_checker.sv]
// Port-level checker for the bipartite two-coloring core, bound to its top level.
// Depends on btc_pkg and bipartite_two_coloring_core.
module btc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic                          o_possible,
    input logic [btc_pkg::WIDX_W-1:0]    o_word_index,
    input logic [btc_pkg::WORD_BITS-1:0] o_team_bits,
    input logic                          o_last_result
);

    // An impossible outcome is a single beat with an empty word.
    a_impossible_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_possible) |-> (o_word_index == '0 && o_team_bits == '0 && o_last_result))
        else $error("impossible result has wrong form");

    a_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat while not busy");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_valid))
        else $error("reset did not start the clearing pass");

    a_words_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_result) |=> !o_valid)
        else $error("result beats back to back within a job");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_result) |=> busy)
        else $error("no clearing pass after the final beat");

endmodule

bind bipartite_two_coloring_core btc_checker u_btc_checker (.*);

[bench/bipartite_two_coloring_core_test.sv]
// Self-checking bench for bipartite_two_coloring_core: directed graphs, then random edge jobs.
// Keeps its own union-find copy of the graph to predict every coloring word and verdict.
// Depends on btc_pkg and the core RTL only.
module bipartite_two_coloring_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_LIMIT    = btc_pkg::NODE_CAP;
    localparam int WORDS_MAX     = btc_pkg::NODE_CAP / btc_pkg::WORD_BITS;
    localparam int RANDOM_ITEMS  = 255;
    localparam int IDLE_LIMIT    = 20000;
    localparam int DRAIN_CYCLES  = 1100;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic           possible;
        btc_pkg::t_widx word_index;
        btc_pkg::t_word team_bits;
        logic           last_result;
    } t_coloring;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    btc_pkg::t_node i_node_a;
    btc_pkg::t_node i_node_b;
    logic           i_has_edge;
    logic           i_last_item;
    logic           i_cfg_we;
    btc_pkg::t_node i_cfg_data;
    logic           o_valid;
    logic           o_possible;
    btc_pkg::t_widx o_word_index;
    btc_pkg::t_word o_team_bits;
    logic           o_last_result;

    logic [9:0]     link_of [btc_pkg::NODE_CAP];
    logic           par_of [btc_pkg::NODE_CAP];
    logic           odd_cycle_seen;
    btc_pkg::t_node node_count_q;

    t_coloring colorings_due[$];
    t_coloring due_word;
    int        bad_words;
    int        idle_cycles;
    int        burst_left;

    bipartite_two_coloring_core #(
        .MAX_NODES(NODE_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_node_a(i_node_a),
        .i_node_b(i_node_b),
        .i_has_edge(i_has_edge),
        .i_last_item(i_last_item),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_possible(o_possible),
        .o_word_index(o_word_index),
        .o_team_bits(o_team_bits),
        .o_last_result(o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int active_nodes();
        int n;
        n = int'(node_count_q);
        if (n == 0) n = 1;
        if (n > NODE_LIMIT) n = NODE_LIMIT;
        return n;
    endfunction

    function automatic int root_of(input int x, output logic p);
        int steps;
        p = 1'b0;
        for (steps = 0; steps < NODE_LIMIT && int'(link_of[x]) != x; steps++) begin
            p ^= par_of[x];
            x = int'(link_of[x]);
        end
        return x;
    endfunction

    task automatic graph_clear();
        int i;
        for (i = 0; i < btc_pkg::NODE_CAP; i++) begin
            link_of[i] = i[9:0];
            par_of[i]  = 1'b0;
        end
        odd_cycle_seen = 1'b0;
    endtask

    task automatic merge_edge(input int a, input int b);
        int   ra;
        int   rb;
        int   t;
        logic pa;
        logic pb;
        ra = root_of(a, pa);
        rb = root_of(b, pb);
        if (ra == rb) begin
            if (pa == pb) odd_cycle_seen = 1'b1;
            return;
        end
        if (ra < rb) begin
            t  = ra;
            ra = rb;
            rb = t;
        end
        link_of[ra] = rb[9:0];
        par_of[ra]  = ~(pa ^ pb);
    endtask

    task automatic predict_coloring(input btc_pkg::t_node a, input btc_pkg::t_node b,
                                    input logic has_edge, input logic last);
        int             n;
        int             words;
        int             w;
        int             i;
        int             r;
        logic           p;
        logic           seen [btc_pkg::NODE_CAP];
        logic           first_par [btc_pkg::NODE_CAP];
        btc_pkg::t_word bits [WORDS_MAX];
        t_coloring      word_out;
        n = active_nodes();
        if (has_edge && a >= 1 && b >= 1 && a <= n && b <= n) merge_edge(int'(a) - 1, int'(b) - 1);
        if (!last) return;
        if (odd_cycle_seen) begin
            word_out = '{possible: 1'b0, word_index: '0, team_bits: '0, last_result: 1'b1};
            colorings_due.insert(colorings_due.size(), word_out);
            graph_clear();
            return;
        end
        for (i = 0; i < btc_pkg::NODE_CAP; i++) begin
            seen[i]      = 1'b0;
            first_par[i] = 1'b0;
        end
        for (w = 0; w < WORDS_MAX; w++) bits[w] = '0;
        for (i = 0; i < n; i++) begin
            r = root_of(i, p);
            if (!seen[r]) begin
                seen[r]      = 1'b1;
                first_par[r] = p;
            end
            if (p ^ first_par[r]) bits[i / btc_pkg::WORD_BITS][i % btc_pkg::WORD_BITS] = 1'b1;
        end
        words = (n + btc_pkg::WORD_BITS - 1) / btc_pkg::WORD_BITS;
        for (w = 0; w < words; w++) begin
            word_out = '{possible: 1'b1, word_index: w[btc_pkg::WIDX_W-1:0], team_bits: bits[w],
                         last_result: (w == words - 1)};
            colorings_due.insert(colorings_due.size(), word_out);
        end
        graph_clear();
    endtask

    task automatic report_word(input string why, input t_coloring want);
        bad_words++;
        if (bad_words <= REPORT_LIMIT) begin
            $display("%s: expected possible=%0b word=%0d bits=%h last=%0b", why,
                     want.possible, want.word_index, want.team_bits, want.last_result);
            $display("    got possible=%0b word=%0d bits=%h last=%0b",
                     o_possible, o_word_index, o_team_bits, o_last_result);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (colorings_due.size() == 0) begin
                report_word("unexpected result", '0);
            end else begin
                due_word = colorings_due.pop_front();
                if (o_possible !== due_word.possible || o_word_index !== due_word.word_index ||
                    o_team_bits !== due_word.team_bits ||
                    o_last_result !== due_word.last_result) begin
                    report_word("result mismatch", due_word);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL bipartite_two_coloring_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input btc_pkg::t_node a, input btc_pkg::t_node b,
                             input logic has_edge, input logic last);
        start       <= 1'b1;
        i_node_a    <= a;
        i_node_b    <= b;
        i_has_edge  <= has_edge;
        i_last_item <= last;
        do @(posedge i_clk); while (busy);
        predict_coloring(a, b, has_edge, last);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic settle_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (colorings_due.size() != 0);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic cfg_write(input btc_pkg::t_node value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        node_count_q = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic pace();
        burst_left--;
        if (burst_left <= 0) begin
            hold_off($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    function automatic btc_pkg::t_node pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return btc_pkg::t_node'($urandom_range(2, 40));
        if (r < 88) return btc_pkg::t_node'($urandom_range(41, 200));
        if (r < 94) return btc_pkg::t_node'($urandom_range(201, 1023));
        if (r < 97) return btc_pkg::t_node'(NODE_LIMIT);
        return $urandom_range(0, 1) ? btc_pkg::t_node'(0)
                                    : btc_pkg::t_node'($urandom_range(1025, 2047));
    endfunction

    task automatic test_empty_and_self_loop();
        send_item(11'd0, 11'd0, 1'b0, 1'b1);
        settle_idle();
        cfg_write(11'd0);
        send_item(11'd1, 11'd1, 1'b1, 1'b1);
    endtask

    task automatic test_extreme_counts();
        settle_idle();
        cfg_write(11'd2047);
        send_item(11'd1, 11'd1024, 1'b1, 1'b0);
        send_item(11'd1024, 11'd2047, 1'b1, 1'b0);
        send_item(11'd0, 11'd5, 1'b1, 1'b0);
        send_item(11'd2047, 11'd2047, 1'b1, 1'b0);
        send_item(11'd1023, 11'd1024, 1'b1, 1'b0);
        send_item(11'd512, 11'd513, 1'b1, 1'b1);
        settle_idle();
        cfg_write(11'd1024);
        send_item(11'd1024, 11'd1, 1'b1, 1'b1);
    endtask

    task automatic test_odd_and_even_cycles();
        settle_idle();
        cfg_write(11'd3);
        send_item(11'd1, 11'd2, 1'b1, 1'b0);
        send_item(11'd2, 11'd3, 1'b1, 1'b0);
        send_item(11'd3, 11'd1, 1'b1, 1'b1);
        settle_idle();
        cfg_write(11'd64);
        send_item(11'd1, 11'd2, 1'b1, 1'b0);
        send_item(11'd2, 11'd3, 1'b1, 1'b0);
        send_item(11'd3, 11'd4, 1'b1, 1'b0);
        send_item(11'd4, 11'd1, 1'b1, 1'b1);
        settle_idle();
        cfg_write(11'd65);
        send_item(11'd65, 11'd64, 1'b1, 1'b0);
        send_item(11'd66, 11'd1, 1'b1, 1'b0);
        send_item(11'd0, 11'd0, 1'b0, 1'b1);
    endtask

    task automatic test_count_changes();
        settle_idle();
        cfg_write(11'd10);
        send_item(11'd9, 11'd10, 1'b1, 1'b0);
        settle_idle();
        cfg_write(11'd5);
        send_item(11'd9, 11'd2, 1'b1, 1'b0);
        send_item(11'd1, 11'd2, 1'b1, 1'b1);
        settle_idle();
        cfg_write(11'd4);
        send_item(11'd3, 11'd3, 1'b1, 1'b0);
        settle_idle();
        cfg_write(11'd2);
        send_item(11'd0, 11'd0, 1'b0, 1'b0);
        send_item(11'd0, 11'd0, 1'b0, 1'b1);
    endtask

    task automatic test_random_jobs();
        int             counted;
        int             edges;
        int             k;
        int             n;
        int             tries;
        bit             split;
        bit             last_edge;
        logic           side [btc_pkg::NODE_CAP];
        btc_pkg::t_node a;
        btc_pkg::t_node b;
        counted    = 0;
        burst_left = $urandom_range(1, 8);
        while (counted < RANDOM_ITEMS) begin
            settle_idle();
            cfg_write(pick_count());
            split = ($urandom_range(0, 2) != 0);
            for (k = 0; k < btc_pkg::NODE_CAP; k++) side[k] = 1'($urandom_range(0, 1));
            edges = $urandom_range(1, 12);
            for (k = 0; k < edges; k++) begin
                n = active_nodes();
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 2))
                        0: send_item(btc_pkg::t_node'($urandom_range(0, 2047)),
                                     btc_pkg::t_node'($urandom_range(0, 2047)), 1'b0, 1'b0);
                        1: send_item(11'd0, btc_pkg::t_node'($urandom_range(0, 2047)),
                                     1'b1, 1'b0);
                        default: send_item(btc_pkg::t_node'($urandom_range(1, n)),
                                           btc_pkg::t_node'($urandom_range(n + 1, 2047)),
                                           1'b1, 1'b0);
                    endcase
                    pace();
                end
                if (k != 0 && $urandom_range(0, 19) == 0) begin
                    settle_idle();
                    cfg_write(pick_count());
                    n = active_nodes();
                end
                a = btc_pkg::t_node'($urandom_range(1, n));
                b = btc_pkg::t_node'($urandom_range(1, n));
                for (tries = 0; split && tries < 8 && side[b-1] == side[a-1]; tries++) begin
                    b = btc_pkg::t_node'($urandom_range(1, n));
                end
                last_edge = (k == edges - 1);
                if ($urandom_range(0, 1)) send_item(a, b, !last_edge || $urandom_range(0, 3) != 0,
                                                    last_edge);
                else send_item(b, a, !last_edge || $urandom_range(0, 3) != 0, last_edge);
                counted++;
                pace();
            end
        end
    endtask

    initial begin
        bad_words    = 0;
        node_count_q = 11'd1;
        graph_clear();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_node_a    <= '0;
        i_node_b    <= '0;
        i_has_edge  <= 1'b0;
        i_last_item <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_self_loop();
        test_extreme_counts();
        test_odd_and_even_cycles();
        test_count_changes();
        test_random_jobs();

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_words == 0 && colorings_due.size() == 0) begin
            $display("PASS bipartite_two_coloring_core");
        end else begin
            $display("FAIL bipartite_two_coloring_core");
        end
        $finish;
    end

endmodule
